### sv/tfp_pkg.sv
// package for the telemetry frame parser
// holds framing constants, command/status structs and ring sizing; no dependencies
`timescale 1ns / 1ps

package tfp_pkg;

  // user data ring
  localparam int unsigned USER_QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(USER_QUEUE_DEPTH);

  // framing bytes
  localparam logic [7:0] SYNC_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_SYNC   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] TYPE_TELEM = 8'hFE;
  localparam logic [7:0] TYPE_USER  = 8'hFD;

  // frame positions
  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_SYNC2    = 4'd1;
  localparam logic [3:0] POS_TYPE     = 4'd2;
  localparam logic [3:0] POS_PAYLOAD  = 4'd3;
  localparam logic [3:0] POS_FULL     = 4'd11;

  localparam int unsigned PAYLOAD_LEN = 8;
  localparam logic [7:0]  USER_MAX    = 8'd6;
  localparam logic [7:0]  HIST_RESET  = 8'd100;

  // operation codes
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_POP     = 1'b1;

  // frame_committed codes
  localparam logic [1:0] COMMIT_NONE  = 2'd0;
  localparam logic [1:0] COMMIT_TELEM = 2'd1;
  localparam logic [1:0] COMMIT_USER  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       parse;
    logic       pop;
    logic       push;
    logic [2:0] push_idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic [2:0] push_n;
  } status_t;

endpackage

### sv/tfp_if.sv
// valid/ready channel interfaces for the telemetry frame parser
// depends on nothing but the port widths of the block
`timescale 1ns / 1ps

interface tfp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface tfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sensor_one;
  logic [7:0] sensor_two;
  logic [7:0] rssi_up;
  logic [7:0] rssi_down;
  logic [7:0] user_byte;
  logic       user_byte_valid;
  logic       user_waiting;
  logic [1:0] frame_committed;

  modport source (
    output valid, output sensor_one, output sensor_two, output rssi_up,
    output rssi_down, output user_byte, output user_byte_valid,
    output user_waiting, output frame_committed, input ready
  );
  modport sink (
    input valid, input sensor_one, input sensor_two, input rssi_up,
    input rssi_down, input user_byte, input user_byte_valid,
    input user_waiting, input frame_committed, output ready
  );
endinterface

### sv/telemetry_frame_parser.sv
// Telemetry frame parser. Each input item is either a received serial byte
// (operation 0) or a request to pop one user data byte (operation 1); each item
// gives exactly one result item carrying the sensor values, the averaged rssi
// figures, the popped byte and the commit code. Items are taken one at a time:
// a received byte is parsed in the execute state and, when it commits a user
// frame, its stored bytes (1 to 6) are written to the ring one at a time, since
// the user ring has a single write port; a pop passes through an extra wait
// state because the ring read is registered. The input is ready again in the
// cycle after the result is loaded; no new item is taken before the last is
// through. The result sits in an output register, so the next item is accepted
// while an earlier result still waits to be taken. The user ring holds up to
// tfp_pkg::USER_QUEUE_DEPTH-1 bytes; on overflow it loses unread data.
// uses tfp_pkg, tfp_if, tfp_ctrl, tfp_datapath
`timescale 1ns / 1ps

module telemetry_frame_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfp_in_if.sink    in_i,
  tfp_out_if.source out_o
);

  tfp_pkg::cmd_t    cmd;
  tfp_pkg::status_t status;

  tfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tfp_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (in_i.operation),
    .rx_byte_i         (in_i.rx_byte),
    .sensor_one_o      (out_o.sensor_one),
    .sensor_two_o      (out_o.sensor_two),
    .rssi_up_o         (out_o.rssi_up),
    .rssi_down_o       (out_o.rssi_down),
    .user_byte_o       (out_o.user_byte),
    .user_byte_valid_o (out_o.user_byte_valid),
    .user_waiting_o    (out_o.user_waiting),
    .frame_committed_o (out_o.frame_committed)
  );

endmodule

### sv/tfp_ram.sv
// generic single write port ram with registered read
// standalone, no package use
`timescale 1ns / 1ps

module tfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/tfp_ctrl.sv
// controller for the telemetry frame parser: sequences parse, ring writes and pops
// uses tfp_pkg command/status structs
`timescale 1ns / 1ps

module tfp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tfp_pkg::status_t status_i,
  output tfp_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_POP_WAIT,
    S_DONE
  } state_e;

  state_e     state_q;
  logic [2:0] push_cnt_q;
  logic [2:0] push_n_q;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.push_idx = push_cnt_q;
    case (state_q)
      S_IDLE:     cmd_o.accept   = in_valid_i;
      S_EXEC: begin
        cmd_o.parse = (status_i.op == tfp_pkg::OP_RX_BYTE);
        cmd_o.pop   = (status_i.op == tfp_pkg::OP_POP);
      end
      S_PUSH:     cmd_o.push     = 1'b1;
      S_POP_WAIT: cmd_o.load_out = 1'b0;
      S_DONE:     cmd_o.load_out = slot_free;
      default:    cmd_o          = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      push_cnt_q  <= '0;
      push_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          push_cnt_q <= '0;
          push_n_q   <= status_i.push_n;
          if (status_i.op == tfp_pkg::OP_POP) begin
            state_q <= S_POP_WAIT;
          end else if (status_i.push_n != 3'd0) begin
            state_q <= S_PUSH;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PUSH: begin
          push_cnt_q <= push_cnt_q + 3'd1;
          if (push_cnt_q + 3'd1 == push_n_q) begin
            state_q <= S_DONE;
          end
        end
        S_POP_WAIT: state_q <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/tfp_datapath.sv
// datapath for the telemetry frame parser: frame registers, rssi history, user ring
// uses tfp_pkg and tfp_ram
`timescale 1ns / 1ps

module tfp_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tfp_pkg::cmd_t    cmd_i,
  output tfp_pkg::status_t status_o,
  input  logic             operation_i,
  input  logic [7:0]       rx_byte_i,
  output logic [7:0]       sensor_one_o,
  output logic [7:0]       sensor_two_o,
  output logic [7:0]       rssi_up_o,
  output logic [7:0]       rssi_down_o,
  output logic [7:0]       user_byte_o,
  output logic             user_byte_valid_o,
  output logic             user_waiting_o,
  output logic [1:0]       frame_committed_o
);

  localparam logic [tfp_pkg::PTR_W-1:0] PTR_LAST =
    tfp_pkg::PTR_W'(tfp_pkg::USER_QUEUE_DEPTH - 1);

  // latched item
  logic       op_q;
  logic [7:0] rx_q;

  // frame parser state
  logic [3:0] pos_q, pos_d;
  logic       esc_q, esc_d;
  logic [7:0] type_q;
  logic [7:0] payload_q [tfp_pkg::PAYLOAD_LEN];
  logic       type_we;
  logic       pay_we;
  logic [2:0] pay_idx;
  logic [7:0] pay_wdata;
  logic [3:0] pos_eff;
  logic [3:0] pos_off;
  logic       commit_now;
  logic [1:0] commit_code;
  logic [2:0] push_n;

  // telemetry state
  logic [7:0] sensor_one_q;
  logic [7:0] sensor_two_q;
  logic [7:0] up_hist_q   [4];
  logic [7:0] down_hist_q [4];
  logic [9:0] up_sum;
  logic [9:0] down_sum;

  // ring
  logic [tfp_pkg::PTR_W-1:0] rp_q;
  logic [tfp_pkg::PTR_W-1:0] wp_q;
  logic                      ring_empty;
  logic                      ram_re;
  logic [7:0]                ram_rdata;
  logic                      uvalid_q;
  logic [1:0]                committed_q;

  assign ring_empty = (rp_q == wp_q);
  assign ram_re     = cmd_i.pop && !ring_empty;

  // parse step for one received byte
  always_comb begin
    commit_now  = (pos_q == tfp_pkg::POS_FULL) && (rx_q == tfp_pkg::SYNC_BYTE);
    pos_eff     = (pos_q == tfp_pkg::POS_FULL) ? tfp_pkg::POS_HUNT : pos_q;
    pos_off     = pos_eff - tfp_pkg::POS_PAYLOAD;
    pay_idx     = pos_off[2:0];
    commit_code = tfp_pkg::COMMIT_NONE;
    push_n      = 3'd0;
    if (commit_now) begin
      if (type_q == tfp_pkg::TYPE_TELEM) begin
        commit_code = tfp_pkg::COMMIT_TELEM;
      end else if (type_q == tfp_pkg::TYPE_USER) begin
        commit_code = tfp_pkg::COMMIT_USER;
        if (payload_q[0] != 8'd0 && payload_q[0] <= tfp_pkg::USER_MAX) begin
          push_n = payload_q[0][2:0];
        end
      end
    end

    pos_d     = pos_eff;
    esc_d     = 1'b0;
    type_we   = 1'b0;
    pay_we    = 1'b0;
    pay_wdata = rx_q;
    case (pos_eff)
      tfp_pkg::POS_HUNT: begin
        if (rx_q == tfp_pkg::SYNC_BYTE) begin
          pos_d = tfp_pkg::POS_SYNC2;
        end
      end
      tfp_pkg::POS_SYNC2: begin
        pos_d = (rx_q == tfp_pkg::SYNC_BYTE) ? tfp_pkg::POS_TYPE : tfp_pkg::POS_HUNT;
      end
      tfp_pkg::POS_TYPE: begin
        if (rx_q == tfp_pkg::TYPE_TELEM || rx_q == tfp_pkg::TYPE_USER) begin
          type_we = 1'b1;
          pos_d   = tfp_pkg::POS_PAYLOAD;
        end
      end
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: begin
        if (esc_q) begin
          if (rx_q == tfp_pkg::ESC_SYNC) begin
            pay_we    = 1'b1;
            pay_wdata = tfp_pkg::SYNC_BYTE;
            pos_d     = pos_eff + 4'd1;
          end else if (rx_q == tfp_pkg::ESC_ESC) begin
            pay_we    = 1'b1;
            pay_wdata = tfp_pkg::ESC_BYTE;
            pos_d     = pos_eff + 4'd1;
          end else begin
            // bad escape drops the frame
            pos_d = tfp_pkg::POS_HUNT;
          end
        end else begin
          pay_we = 1'b1;
          if (rx_q == tfp_pkg::ESC_BYTE) begin
            esc_d = 1'b1;
          end else begin
            pos_d = pos_eff + 4'd1;
          end
        end
      end
      default: pos_d = tfp_pkg::POS_HUNT;
    endcase
  end

  assign status_o.op     = op_q;
  assign status_o.push_n = push_n;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= operation_i;
      rx_q <= rx_byte_i;
    end
    if (cmd_i.parse) begin
      committed_q <= commit_code;
      uvalid_q    <= 1'b0;
      if (type_we) begin
        type_q <= rx_q;
      end
      if (pay_we) begin
        payload_q[pay_idx] <= pay_wdata;
      end
    end
    if (cmd_i.pop) begin
      committed_q <= tfp_pkg::COMMIT_NONE;
      uvalid_q    <= !ring_empty;
    end
    if (cmd_i.load_out) begin
      sensor_one_o      <= sensor_one_q;
      sensor_two_o      <= sensor_two_q;
      rssi_up_o         <= up_sum[9:2];
      rssi_down_o       <= down_sum[9:2];
      user_byte_o       <= uvalid_q ? ram_rdata : 8'd0;
      user_byte_valid_o <= uvalid_q;
      user_waiting_o    <= !ring_empty;
      frame_committed_o <= committed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= tfp_pkg::POS_HUNT;
      esc_q        <= 1'b0;
      sensor_one_q <= 8'd0;
      sensor_two_q <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        up_hist_q[i]   <= tfp_pkg::HIST_RESET;
        down_hist_q[i] <= tfp_pkg::HIST_RESET;
      end
      rp_q <= '0;
      wp_q <= '0;
    end else begin
      if (cmd_i.parse) begin
        pos_q <= pos_d;
        esc_q <= esc_d;
        if (commit_code == tfp_pkg::COMMIT_TELEM) begin
          sensor_one_q <= payload_q[0];
          sensor_two_q <= payload_q[1];
          for (int i = 0; i < 3; i++) begin
            up_hist_q[i]   <= up_hist_q[i+1];
            down_hist_q[i] <= down_hist_q[i+1];
          end
          up_hist_q[3]   <= payload_q[2];
          down_hist_q[3] <= {1'b0, payload_q[3][7:1]};
        end
      end
      if (cmd_i.push) begin
        wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
      end
      if (ram_re) begin
        rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
      end
    end
  end

  always_comb begin
    up_sum   = {2'b00, up_hist_q[0]} + {2'b00, up_hist_q[1]}
             + {2'b00, up_hist_q[2]} + {2'b00, up_hist_q[3]};
    down_sum = {2'b00, down_hist_q[0]} + {2'b00, down_hist_q[1]}
             + {2'b00, down_hist_q[2]} + {2'b00, down_hist_q[3]};
  end

  logic [2:0] push_sel;
  assign push_sel = cmd_i.push_idx + 3'd1;

  tfp_ram #(
    .WIDTH (8),
    .DEPTH (tfp_pkg::USER_QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wp_q),
    .wdata_i (payload_q[push_sel]),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

endmodule

### sv/tfp_checker.sv
// port level checks for the telemetry frame parser, bound to the top level
// uses tfp_pkg codes
`timescale 1ns / 1ps

module tfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] user_byte_i,
  input logic       user_byte_valid_i,
  input logic [1:0] frame_committed_i
);

  // result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one item in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_committed_i == tfp_pkg::COMMIT_NONE
                 || frame_committed_i == tfp_pkg::COMMIT_TELEM
                 || frame_committed_i == tfp_pkg::COMMIT_USER)
    else $error("bad commit code");

  // a commit only comes from a received byte, never from a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_committed_i != tfp_pkg::COMMIT_NONE |-> !user_byte_valid_i)
    else $error("commit and popped byte in one item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !user_byte_valid_i |-> user_byte_i == 8'd0)
    else $error("user byte not cleared without a pop");

endmodule

bind telemetry_frame_parser tfp_checker u_tfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .user_byte_i       (out_o.user_byte),
  .user_byte_valid_i (out_o.user_byte_valid),
  .frame_committed_i (out_o.frame_committed)
);
